>>> rtl/sttg_pkg.sv
package sttg_pkg;

  localparam int unsigned DIV_W       = 32;
  localparam int unsigned HP_W        = 19;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]       IDLE_CODE       = 8'd128;
  localparam logic [DIV_W-1:0] HALF_PERIOD_NUM = 32'd500000;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_VOLUME    = 2'd0,
    REG_FREQUENCY = 2'd1,
    REG_DURATION  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLS_TICK  = 2'd0,
    CLS_START = 2'd1,
    CLS_STOP  = 2'd2,
    CLS_NONE  = 2'd3
  } cls_e;

  typedef struct packed {
    cls_e        cls;
    logic [31:0] now_ms;
    logic [31:0] now_us;
  } item_t;

  typedef struct packed {
    logic [7:0]  volume;
    logic [15:0] frequency;
    logic [31:0] duration;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [HP_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [HP_W-1:0]  remainder;
  } div_rsp_t;

  // floor(64 * vol / 255)
  function automatic logic [7:0] level_mag(logic [7:0] vol);
    logic [7:0] mag;
    mag = {2'b00, vol[7:2]} + {7'b0, (vol == 8'hFF)};
    return mag;
  endfunction

endpackage

>>> rtl/square_test_tone_generator_unit.sv
// Path: start and catch-up ticks pass from acceptance through the 32-step radix-2 divider
// before the result word is offered; stop, refused start and plain ticks bypass the divider.
// Flow: one word at a time through the back end, which takes no new word until the last is sent;
// a two-word queue lets the input side keep accepting while the back end works.
// Reset: asynchronous, active low; tone idle, volume 255, frequency and duration 0.
module square_test_tone_generator_unit #(
  parameter int unsigned QueueDepth = sttg_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] now_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        dac_write_o,
  output logic [7:0]  dac_value_o,
  output logic        start_accepted_o,
  output logic        playing_o,
  output logic [31:0] elapsed_ms_o
);
  import sttg_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_VOLUME:    cfg_d.volume    = cfg_wdata_i[7:0];
        REG_FREQUENCY: cfg_d.frequency = cfg_wdata_i[15:0];
        REG_DURATION:  cfg_d.duration  = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volume    <= 8'hFF;
      cfg_q.frequency <= '0;
      cfg_q.duration  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sttg_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .now_ms_i   (now_ms_i),
    .now_us_i   (now_us_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  sttg_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .dac_write_o      (dac_write_o),
    .dac_value_o      (dac_value_o),
    .start_accepted_o (start_accepted_o),
    .playing_o        (playing_o),
    .elapsed_ms_o     (elapsed_ms_o)
  );

endmodule

>>> rtl/sttg_div.sv
module sttg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sttg_pkg::div_req_t req_i,
  output sttg_pkg::div_rsp_t rsp_o
);
  import sttg_pkg::*;

  localparam int unsigned CntW = $clog2(DIV_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [HP_W-1:0]  rem_q, rem_d;
  logic [HP_W-1:0]  dvs_q, dvs_d;
  logic [HP_W:0]    trial;
  logic [HP_W:0]    diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[DIV_W-1]};
    diff   = trial - {1'b0, dvs_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DIV_W - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[HP_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[HP_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> rtl/sttg_front.sv
module sttg_front #(
  parameter int unsigned QueueDepth = sttg_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      command_i,
  input  logic [31:0]     now_ms_i,
  input  logic [31:0]     now_us_i,
  output logic            q_valid_o,
  output sttg_pkg::item_t q_item_o,
  input  logic            q_pop_i
);
  import sttg_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t           fifo_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            full;
  logic            push;
  item_t           item;

  always_comb begin
    item.now_ms = now_ms_i;
    item.now_us = now_us_i;
    case (command_i)
      CMD_TICK:  item.cls = CLS_TICK;
      CMD_START: item.cls = CLS_START;
      CMD_STOP:  item.cls = CLS_STOP;
      default:   item.cls = CLS_NONE;
    endcase
  end

  assign full       = (cnt_q == CntW'(QueueDepth));
  assign push       = in_valid_i && !full;
  assign in_stall_o = full;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

endmodule

>>> rtl/sttg_back.sv
module sttg_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sttg_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  sttg_pkg::item_t q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            dac_write_o,
  output logic [7:0]      dac_value_o,
  output logic            start_accepted_o,
  output logic            playing_o,
  output logic [31:0]     elapsed_ms_o
);
  import sttg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_DIV    = 4'b0100,
    S_RESULT = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  item_t       work_q, work_d;
  logic        active_q, active_d;
  logic        level_q, level_d;
  logic [HP_W-1:0] hp_q, hp_d;
  logic [31:0] started_q, started_d;
  logic [31:0] edge_q, edge_d;
  logic [31:0] latched_q, latched_d;
  logic        wr_q, wr_d;
  logic [7:0]  val_q, val_d;
  logic        acc_q, acc_d;

  logic        out_valid_q, out_valid_d;
  logic        out_wr_q, out_wr_d;
  logic [7:0]  out_val_q, out_val_d;
  logic        out_acc_q, out_acc_d;
  logic        out_play_q, out_play_d;
  logic [31:0] out_elapsed_q, out_elapsed_d;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic [HP_W-1:0] hp_eff;
  logic [31:0] late;
  logic [31:0] run_ms;
  logic [7:0]  mag;
  logic        out_free;

  sttg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign hp_eff   = (hp_q == '0) ? HP_W'(1) : hp_q;
  assign late     = work_q.now_us - edge_q;
  assign run_ms   = work_q.now_ms - started_q;
  assign mag      = level_mag(cfg_i.volume);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    work_d        = work_q;
    active_d      = active_q;
    level_d       = level_q;
    hp_d          = hp_q;
    started_d     = started_q;
    edge_d        = edge_q;
    latched_d     = latched_q;
    wr_d          = wr_q;
    val_d         = val_q;
    acc_d         = acc_q;
    q_pop_o       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = late;
    div_req.divisor  = hp_eff;
    out_valid_d   = out_valid_q && out_stall_i;
    out_wr_d      = out_wr_q;
    out_val_d     = out_val_q;
    out_acc_d     = out_acc_q;
    out_play_d    = out_play_q;
    out_elapsed_d = out_elapsed_q;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          work_d  = q_item_i;
          wr_d    = 1'b0;
          val_d   = '0;
          acc_d   = 1'b0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESULT;
        case (work_q.cls)
          CLS_START: begin
            if (cfg_i.frequency != '0 && cfg_i.duration != '0) begin
              active_d  = 1'b1;
              level_d   = 1'b0;
              latched_d = cfg_i.duration;
              started_d = work_q.now_ms;
              edge_d    = work_q.now_us;
              wr_d      = 1'b1;
              val_d     = IDLE_CODE;
              acc_d     = 1'b1;
              div_req.start    = 1'b1;
              div_req.dividend = HALF_PERIOD_NUM;
              div_req.divisor  = HP_W'(cfg_i.frequency);
              state_d   = S_DIV;
            end
          end
          CLS_STOP: begin
            active_d = 1'b0;
            level_d  = 1'b0;
            wr_d     = 1'b1;
            val_d    = IDLE_CODE;
          end
          CLS_TICK: begin
            if (active_q) begin
              if (run_ms >= latched_q) begin
                active_d = 1'b0;
                level_d  = 1'b0;
                wr_d     = 1'b1;
                val_d    = IDLE_CODE;
              end else if (!late[31]) begin
                div_req.start = 1'b1;
                state_d       = S_DIV;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (work_q.cls == CLS_START) begin
            hp_d = div_rsp.quotient[HP_W-1:0];
          end else begin
            if (!div_rsp.quotient[0]) begin
              level_d = !level_q;
              wr_d    = 1'b1;
              val_d   = level_q ? (IDLE_CODE - mag) : (IDLE_CODE + mag);
            end
            edge_d = work_q.now_us - 32'(div_rsp.remainder) + 32'(hp_eff);
          end
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_wr_d      = wr_q;
          out_val_d     = val_q;
          out_acc_d     = acc_q;
          out_play_d    = active_q;
          out_elapsed_d = !active_q ? '0 : ((run_ms > latched_q) ? latched_q : run_ms);
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      level_q     <= 1'b0;
      hp_q        <= '0;
      started_q   <= '0;
      edge_q      <= '0;
      latched_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      level_q     <= level_d;
      hp_q        <= hp_d;
      started_q   <= started_d;
      edge_q      <= edge_d;
      latched_q   <= latched_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q        <= work_d;
    wr_q          <= wr_d;
    val_q         <= val_d;
    acc_q         <= acc_d;
    out_wr_q      <= out_wr_d;
    out_val_q     <= out_val_d;
    out_acc_q     <= out_acc_d;
    out_play_q    <= out_play_d;
    out_elapsed_q <= out_elapsed_d;
  end

  assign out_valid_o      = out_valid_q;
  assign dac_write_o      = out_wr_q;
  assign dac_value_o      = out_val_q;
  assign start_accepted_o = out_acc_q;
  assign playing_o        = out_play_q;
  assign elapsed_ms_o     = out_elapsed_q;

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> state_q == S_DIV)
    else $error("divider busy outside division state");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == S_IDLE && q_valid_i))
    else $error("queue popped while back end busy");

  a_accept_plays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && start_accepted_o) |-> (playing_o && dac_write_o))
    else $error("accepted start without tone");

  a_idle_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !playing_o) |-> elapsed_ms_o == '0)
    else $error("elapsed time reported while idle");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !dac_write_o) |-> dac_value_o == '0)
    else $error("DAC value without write");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sttg_pkg::*;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [31:0] SWING       = 32'd64;
  localparam logic [31:0] FULL_SCALE  = 32'd255;
  localparam int unsigned HOLD_AFTER  = 300;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned END_CYCLES  = 40;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] ms;
    logic [31:0] us;
  } tone_ev_t;

  typedef struct packed {
    logic        dac_write;
    logic [7:0]  dac_value;
    logic        start_accepted;
    logic        playing;
    logic [31:0] elapsed_ms;
  } tone_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = '0;
  logic [31:0] now_ms_i = '0;
  logic [31:0] now_us_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        dac_write_o;
  logic [7:0]  dac_value_o;
  logic        start_accepted_o;
  logic        playing_o;
  logic [31:0] elapsed_ms_o;

  square_test_tone_generator_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .now_ms_i        (now_ms_i),
    .now_us_i        (now_us_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .dac_write_o     (dac_write_o),
    .dac_value_o     (dac_value_o),
    .start_accepted_o(start_accepted_o),
    .playing_o       (playing_o),
    .elapsed_ms_o    (elapsed_ms_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // register copies and tone state as the block should hold them
  logic [7:0]  vol_now  = 8'd255;
  logic [15:0] freq_now = '0;
  logic [31:0] dur_now  = '0;
  logic        sounding = 1'b0;
  logic        level_hi = 1'b0;
  logic [18:0] half_us  = '0;
  logic [31:0] start_ms = '0;
  logic [31:0] edge_us  = '0;
  logic [31:0] held_dur = '0;

  tone_ev_t    events_pending[$];
  tone_word_t  words_due[$];
  int unsigned queued;
  int unsigned words_in;
  int unsigned faults;
  bit          in_fire;
  bit          calm;

  task automatic tone_event(input tone_ev_t ev, output tone_word_t w);
    logic [31:0] span, late, hp, periods, mag;
    w = '0;
    case (ev.command)
      CMD_START: begin
        if (freq_now != 0 && dur_now != 0) begin
          level_hi = 1'b0;
          half_us  = 19'(HALF_PERIOD_NUM / freq_now);
          held_dur = dur_now;
          start_ms = ev.ms;
          edge_us  = ev.us;
          sounding = 1'b1;
          w.dac_write      = 1'b1;
          w.dac_value      = IDLE_CODE;
          w.start_accepted = 1'b1;
        end
      end
      CMD_STOP: begin
        sounding    = 1'b0;
        level_hi    = 1'b0;
        w.dac_write = 1'b1;
        w.dac_value = IDLE_CODE;
      end
      CMD_TICK: begin
        if (sounding) begin
          span = ev.ms - start_ms;
          if (span >= held_dur) begin
            sounding    = 1'b0;
            level_hi    = 1'b0;
            w.dac_write = 1'b1;
            w.dac_value = IDLE_CODE;
          end else begin
            late = ev.us - edge_us;
            if (!late[31]) begin
              hp      = (half_us != 0) ? 32'(half_us) : 32'd1;
              periods = late / hp + 32'd1;
              if (periods[0]) begin
                level_hi    = !level_hi;
                mag         = (SWING * vol_now) / FULL_SCALE;
                w.dac_write = 1'b1;
                w.dac_value = level_hi ? IDLE_CODE + mag[7:0] : IDLE_CODE - mag[7:0];
              end
              edge_us = edge_us + periods * hp;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (sounding) begin
      span = ev.ms - start_ms;
      w.elapsed_ms = (span > held_dur) ? held_dur : span;
    end
    w.playing = sounding;
  endtask

  function automatic string describe(tone_word_t w);
    return $sformatf("write=%0b value=%0d accepted=%0b playing=%0b elapsed=%0d",
                     w.dac_write, w.dac_value, w.start_accepted, w.playing, w.elapsed_ms);
  endfunction

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    tone_word_t want, got;
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (in_fire) begin
      tone_event(tone_ev_t'{command_i, now_ms_i, now_us_i}, want);
      words_due.push_back(want);
      words_in++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {dac_write_o, dac_value_o, start_accepted_o, playing_o, elapsed_ms_o};
      if (words_due.size() == 0) begin
        note_fault({"result word with none due: ", describe(got)});
      end else begin
        want = words_due.pop_front();
        if (got.dac_write !== want.dac_write || got.dac_value !== want.dac_value ||
            got.start_accepted !== want.start_accepted || got.playing !== want.playing ||
            got.elapsed_ms !== want.elapsed_ms) begin
          note_fault({"expected ", describe(want), " got ", describe(got)});
        end
      end
    end
  end

  int unsigned gap_left, steady_left;

  always @(negedge clk_i) begin
    tone_ev_t ev;
    if (!in_valid_i || in_fire) begin
      if (gap_left != 0 && !calm) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (events_pending.size() == 0) begin
        in_valid_i <= 1'b0;
      end else begin
        ev = events_pending.pop_front();
        in_valid_i <= 1'b1;
        command_i  <= ev.command;
        now_ms_i   <= ev.ms;
        now_us_i   <= ev.us;
        if (steady_left != 0) steady_left--;
        else if ($urandom_range(0, 1) != 0) gap_left = $urandom_range(1, 13);
        else steady_left = $urandom_range(1, 30);
      end
    end
  end

  int unsigned stall_burst, stall_free, hold_left;
  bit          hold_done;

  always @(negedge clk_i) begin
    logic s;
    s = 1'b0;
    // hold off long enough for the block to back up into its input
    if (!hold_done && words_in >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      s = 1'b1;
      hold_left--;
    end else if (calm) begin
      s = 1'b0;
    end else if (stall_burst != 0) begin
      s = 1'b1;
      stall_burst--;
    end else if (stall_free != 0) begin
      stall_free--;
    end else if ($urandom_range(0, 1) != 0) begin
      s = 1'b1;
      stall_burst = $urandom_range(0, 12);
    end else begin
      stall_free = $urandom_range(1, 40);
    end
    out_stall_i <= s;
  end

  task automatic push_ev(input logic [1:0] c, input logic [31:0] ms, input logic [31:0] us);
    events_pending.push_back(tone_ev_t'{c, ms, us});
    queued++;
  endtask

  task automatic settle();
    while (events_pending.size() != 0 || in_valid_i || words_due.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_VOLUME:    vol_now  = val[7:0];
      REG_FREQUENCY: freq_now = val[15:0];
      REG_DURATION:  dur_now  = val;
      default: begin
      end
    endcase
  endtask

  task automatic set_tone(input logic [7:0] vol, input logic [15:0] freq,
                          input logic [31:0] dur);
    settle();
    write_reg(REG_VOLUME, {24'd0, vol});
    write_reg(REG_FREQUENCY, {16'd0, freq});
    write_reg(REG_DURATION, dur);
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 2000);
      default: return $urandom();
    endcase
  endfunction

  task automatic play_tone();
    logic [31:0] ms, us, t0, edge_at, hp, late;
    ms = pick_time();
    us = pick_time();
    t0 = ms;
    edge_at = us;
    hp = (freq_now != 0) ? HALF_PERIOD_NUM / freq_now : 32'd1;
    push_ev(CMD_START, ms, us);
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 3) == 0) ms += $urandom_range(1, 2);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: us = edge_at + $urandom_range(0, hp - 1);
        4, 5:       us = edge_at + hp * $urandom_range(1, 6) + $urandom_range(0, hp - 1);
        6:          us = edge_at - $urandom_range(1, hp);
        7:          us = $urandom();
        8:          push_ev(($urandom_range(0, 1) != 0) ? CMD_UNUSED : CMD_STOP, ms, us);
        default:    ms = t0 + dur_now + $urandom_range(0, 2);
      endcase
      push_ev(CMD_TICK, ms, us);
      late = us - edge_at;
      if (!late[31]) edge_at += (late / hp + 32'd1) * hp;
    end
    case ($urandom_range(0, 2))
      0: push_ev(CMD_STOP, ms, us);
      1: push_ev(CMD_TICK, t0 + dur_now + $urandom_range(0, 3), us);
      default: begin
      end
    endcase
  endtask

  int unsigned quota;

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_ev(CMD_TICK, 32'h0, 32'h0);
    push_ev(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_ev(CMD_STOP, 32'hFFFF_FFFF, 32'h0);
    push_ev(CMD_UNUSED, 32'h0, 32'hFFFF_FFFF);

    set_tone(8'd255, 16'd1000, 32'd5);
    push_ev(CMD_START, 32'hFFFF_FFFE, 32'hFFFF_FF00);
    push_ev(CMD_TICK, 32'hFFFF_FFFE, 32'hFFFF_FF00);
    push_ev(CMD_TICK, 32'hFFFF_FFFE, 32'hFFFF_FF64);
    push_ev(CMD_TICK, 32'hFFFF_FFFF, 32'h0000_04E6);
    push_ev(CMD_TICK, 32'hFFFF_FFFF, 32'h0000_08C4);
    push_ev(CMD_UNUSED, 32'h0000_0010, 32'h0);
    push_ev(CMD_TICK, 32'h0000_0003, 32'h0000_0900);
    push_ev(CMD_TICK, 32'h0000_0004, 32'h0);
    push_ev(CMD_START, 32'd100, 32'd1000);
    push_ev(CMD_START, 32'd101, 32'd50);
    push_ev(CMD_STOP, 32'd102, 32'd60);

    set_tone(8'd0, 16'd65535, 32'hFFFF_FFFF);
    push_ev(CMD_START, 32'h0, 32'h0);
    push_ev(CMD_TICK, 32'h0, 32'h0);
    push_ev(CMD_TICK, 32'h0, 32'd7);
    push_ev(CMD_TICK, 32'hFFFF_FFFE, 32'd14);
    push_ev(CMD_TICK, 32'hFFFF_FFFF, 32'd30);
    push_ev(CMD_STOP, 32'h0, 32'h0);

    for (int p = 0; p < 12; p++) begin
      case (p)
        0:  set_tone(8'd255, 16'd1, 32'hFFFF_FFFF);
        1:  set_tone(8'd0, 16'd65535, 32'd1);
        2:  set_tone(8'd1, 16'd440, 32'd20);
        3:  set_tone(8'd128, 16'd0, 32'd10);
        4:  set_tone(8'd254, 16'd2000, 32'd0);
        7:  set_tone(8'($urandom()), 16'($urandom_range(1, 65535)), $urandom_range(1, 40));
        11: begin
          set_tone(8'd255, 16'd1000, 32'd8);
          calm = 1'b1;
        end
        default: set_tone(8'($urandom()), 16'($urandom_range(1, 5000)),
                          $urandom_range(1, 40));
      endcase
      quota = queued + 100;
      while (queued < quota) begin
        if ($urandom_range(0, 4) != 0) play_tone();
        else push_ev(2'($urandom_range(0, 3)), pick_time(), pick_time());
      end
    end

    settle();
    repeat (END_CYCLES) @(posedge clk_i);
    if (words_due.size() != 0)
      note_fault($sformatf("%0d result words never arrived", words_due.size()));
    if (faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(900_000 * 8);
    $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
rtl/sttg_pkg.sv
rtl/sttg_div.sv
rtl/sttg_front.sv
rtl/sttg_back.sv
rtl/square_test_tone_generator_unit.sv
tb/sv/testbench.sv
